@@ rtl/spc_pkg.sv @@
// Package for the shortest path counter: sizes, status codes, item kinds.
// No dependencies.
package spc_pkg;
    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;
    localparam int VW = $clog2(MAX_VERTICES);   // vertex index width
    localparam int EW = $clog2(MAX_EDGES);      // edge index width
    localparam int CW = 32;                     // path count width

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;
endpackage

@@ rtl/shortest_path_counter.sv @@
// Shortest path counter top level: edge store, BFS sequencer, memories.
// Depends on spc_pkg and spc_ram.
//
// channel | signals                                   | handshake
// --------+-------------------------------------------+--------------------------
// item in | kind, vertex_a, vertex_b                  | start & !busy
// result  | path_count, count_saturated, status       | done strobe, one cycle
// config  | cfg_data                                  | cfg_valid & cfg_ready
//
// An edge beat passes through S_EDGE before its result strobe; a refused beat
// stays in S_IDLE, its strobe overlapping the next accept. A query first
// sweeps all MAX_VERTICES distance/count entries, one entry per cycle, then
// steps each dequeued vertex through S_POP, S_POPW and S_HEAD and each edge
// walked through S_EDGERD, S_TGT and S_UPD (no S_UPD when the target is past
// the vertex count), then fetches the stop vertex count in S_FIN and S_FINW,
// as set by the single read port of each memory. After reset, a sweep clears
// all list heads, busy high meanwhile. The result receiver cannot stall.
module shortest_path_counter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  logic [spc_pkg::VW-1:0] vertex_a,
    input  logic [spc_pkg::VW-1:0] vertex_b,
    output logic                  done,
    output logic [spc_pkg::CW-1:0] path_count,
    output logic                  count_saturated,
    output logic [1:0]            status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [spc_pkg::VW:0]  cfg_data
);
    import spc_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_EDGE, S_CLR, S_POP, S_POPW, S_HEAD, S_EDGERD,
        S_TGT, S_UPD, S_FIN, S_FINW
    } state_t;

    // hop distance: VW+1 bits, MAX_VERTICES means unreached
    localparam logic [VW:0] UNREACHED = (VW+1)'(MAX_VERTICES);
    localparam logic [EW:0] NO_EDGE   = (EW+1)'(MAX_EDGES);

    state_t           state_reg;
    logic [VW:0]      vcount_reg;
    logic [VW:0]      n_eff;
    logic [EW:0]      used_reg;
    logic [VW:0]      sweep_reg;
    logic [VW-1:0]    a_reg, b_reg;
    logic [VW:0]      rd_reg, wr_reg;
    logic [VW-1:0]    cur_reg;
    logic [VW:0]      nextd_reg;
    logic [CW-1:0]    curcnt_reg;
    logic [EW:0]      e_reg;
    logic [EW:0]      steps_reg;
    logic [VW-1:0]    v_reg;
    logic             sat_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_out_reg;
    logic             sato_reg;
    status_t          st_reg;

    // memory ports
    logic             hd_we;   logic [VW-1:0] hd_wa, hd_ra; logic [EW:0] hd_wd, hd_rd;
    logic             et_we;   logic [EW-1:0] et_wa, et_ra; logic [VW-1:0] et_wd, et_rd;
    logic [EW:0]      el_wd, el_rd;
    logic             dc_we;   logic [VW-1:0] dc_wa, dc_ra;
    logic [VW+CW:0]   dc_wd, dc_rd;   // {distance, count}
    logic             q_we;    logic [VW-1:0] q_wa, q_ra, q_wd, q_rd;

    spc_ram #(.DW(EW+1), .AW(VW)) u_head (.clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd),
        .raddr(hd_ra), .rdata(hd_rd));
    spc_ram #(.DW(VW), .AW(EW)) u_tgt (.clk, .we(et_we), .waddr(et_wa), .wdata(et_wd),
        .raddr(et_ra), .rdata(et_rd));
    spc_ram #(.DW(EW+1), .AW(EW)) u_link (.clk, .we(et_we), .waddr(et_wa), .wdata(el_wd),
        .raddr(et_ra), .rdata(el_rd));
    spc_ram #(.DW(VW+1+CW), .AW(VW)) u_dc (.clk, .we(dc_we), .waddr(dc_wa), .wdata(dc_wd),
        .raddr(dc_ra), .rdata(dc_rd));
    spc_ram #(.DW(VW), .AW(VW)) u_q (.clk, .we(q_we), .waddr(q_wa), .wdata(q_wd),
        .raddr(q_ra), .rdata(q_rd));

    always_comb
    begin
        if (vcount_reg == '0)
            n_eff = (VW+1)'(1);
        else if (vcount_reg > (VW+1)'(MAX_VERTICES))
            n_eff = (VW+1)'(MAX_VERTICES);
        else
            n_eff = vcount_reg;
    end

    logic             in_range;
    logic [VW:0]      dist_rd;
    logic [CW-1:0]    cnt_rd;
    logic [CW:0]      sum;
    assign in_range = ({1'b0, vertex_a} < n_eff) && ({1'b0, vertex_b} < n_eff);
    assign dist_rd  = dc_rd[VW+CW:CW];
    assign cnt_rd   = dc_rd[CW-1:0];
    assign sum      = {1'b0, cnt_rd} + {1'b0, curcnt_reg};

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign done            = done_reg;
    assign path_count      = cnt_out_reg;
    assign count_saturated = sato_reg;
    assign status          = st_reg;

    // memory control
    always_comb
    begin
        hd_we = 1'b0; hd_wa = a_reg; hd_wd = NO_EDGE; hd_ra = cur_reg;
        et_we = 1'b0; et_wa = used_reg[EW-1:0]; et_wd = b_reg; el_wd = hd_rd;
        et_ra = e_reg[EW-1:0];
        dc_we = 1'b0; dc_wa = v_reg; dc_wd = '0; dc_ra = v_reg;
        q_we = 1'b0; q_wa = wr_reg[VW-1:0]; q_wd = v_reg; q_ra = rd_reg[VW-1:0];
        case (state_reg)
            S_INIT:
            begin
                hd_we = 1'b1; hd_wa = sweep_reg[VW-1:0];
            end
            S_IDLE:
            begin
                hd_ra = vertex_a;
            end
            S_EDGE:
            begin
                et_we = 1'b1;
                hd_we = 1'b1; hd_wd = used_reg;
            end
            S_CLR:
            begin
                dc_we = 1'b1; dc_wa = sweep_reg[VW-1:0];
                if (sweep_reg[VW-1:0] == a_reg)
                    dc_wd = {(VW+1)'(0), CW'(1)};
                else
                    dc_wd = {UNREACHED, CW'(0)};
                q_we = 1'b1; q_wa = '0; q_wd = a_reg;
            end
            S_POPW:
            begin
                dc_ra = q_rd;
                hd_ra = q_rd;
            end
            S_TGT:
            begin
                // fetch distance/count of the edge target for S_UPD
                dc_ra = et_rd;
            end
            S_UPD:
            begin
                if (dist_rd == UNREACHED)
                begin
                    dc_we = 1'b1;
                    dc_wd = {nextd_reg, sum[CW] ? {CW{1'b1}} : sum[CW-1:0]};
                    q_we  = wr_reg < (VW+1)'(MAX_VERTICES);
                end
                else if (dist_rd == nextd_reg)
                begin
                    dc_we = 1'b1;
                    dc_wd = {nextd_reg, sum[CW] ? {CW{1'b1}} : sum[CW-1:0]};
                end
            end
            S_FIN:
            begin
                dc_ra = b_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            vcount_reg  <= (VW+1)'(MAX_VERTICES);
            used_reg    <= '0;
            sweep_reg   <= '0;
            done_reg    <= 1'b0;
            sat_reg     <= 1'b0;
            rd_reg      <= '0;
            wr_reg      <= '0;
            cnt_out_reg <= '0;
            sato_reg    <= 1'b0;
            st_reg      <= ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                vcount_reg <= cfg_data;
            case (state_reg)
                S_INIT:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == (VW+1)'(MAX_VERTICES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        a_reg    <= vertex_a;
                        b_reg    <= vertex_b;
                        cnt_out_reg <= '0;
                        sato_reg    <= 1'b0;
                        if (!in_range)
                        begin
                            st_reg <= ST_RANGE; done_reg <= 1'b1;
                        end
                        else if (kind == KIND_EDGE)
                        begin
                            if (used_reg == NO_EDGE)
                            begin
                                st_reg <= ST_FULL; done_reg <= 1'b1;
                            end
                            else
                            begin
                                st_reg <= ST_OK; state_reg <= S_EDGE;
                            end
                        end
                        else
                        begin
                            st_reg <= ST_OK; sweep_reg <= '0; sat_reg <= 1'b0;
                            rd_reg <= '0; wr_reg <= (VW+1)'(1);
                            state_reg <= S_CLR;
                        end
                    end
                end
                S_EDGE:
                begin
                    used_reg  <= used_reg + 1'b1;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_CLR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == (VW+1)'(MAX_VERTICES - 1))
                        state_reg <= S_POP;
                end
                S_POP:
                begin
                    // queue read issued at rd_reg
                    if (rd_reg < wr_reg)
                        state_reg <= S_POPW;
                    else
                        state_reg <= S_FIN;
                end
                S_POPW:
                begin
                    cur_reg   <= q_rd;
                    rd_reg    <= rd_reg + 1'b1;
                    state_reg <= S_HEAD;
                end
                S_HEAD:
                begin
                    nextd_reg  <= dist_rd + 1'b1;
                    curcnt_reg <= cnt_rd;
                    e_reg      <= hd_rd;
                    steps_reg  <= '0;
                    state_reg  <= S_EDGERD;
                end
                S_EDGERD:
                begin
                    if (e_reg < NO_EDGE && steps_reg < NO_EDGE)
                        state_reg <= S_TGT;
                    else
                        state_reg <= S_POP;
                end
                S_TGT:
                begin
                    v_reg     <= et_rd;
                    e_reg     <= el_rd;
                    steps_reg <= steps_reg + 1'b1;
                    if ({1'b0, et_rd} < n_eff)
                        state_reg <= S_UPD;
                    else
                        state_reg <= S_EDGERD;
                end
                S_UPD:
                begin
                    if (dist_rd == UNREACHED || dist_rd == nextd_reg)
                    begin
                        if (sum[CW])
                            sat_reg <= 1'b1;
                        // self-loop onto cur would change the cached count
                        if (v_reg == cur_reg)
                            curcnt_reg <= sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
                    end
                    if (dist_rd == UNREACHED && wr_reg < (VW+1)'(MAX_VERTICES))
                        wr_reg <= wr_reg + 1'b1;
                    state_reg <= S_EDGERD;
                end
                S_FIN:
                begin
                    state_reg <= S_FINW;
                end
                S_FINW:
                begin
                    cnt_out_reg <= cnt_rd;
                    sato_reg    <= sat_reg && (cnt_rd == {CW{1'b1}});
                    done_reg    <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

@@ rtl/spc_ram.sv @@
// Generic single-port-write, single-read synchronous RAM, registered read data.
// No dependencies.
module spc_ram #(
    parameter int DW = 8,
    parameter int AW = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for shortest_path_counter: random and directed graph builds and queries.
// Depends on spc_pkg and the shortest_path_counter RTL.
module tb_top;
    import spc_pkg::*;

    localparam int HALF_PERIOD = 4;
    // Longest quiet stretch: the post-reset list sweep, then a query over a full
    // store (the memory sweep, then the walk over every vertex and every edge),
    // padded several times over.
    localparam int QUIET_LIMIT = 80000;
    localparam logic [CW-1:0] COUNT_TOP = '1;
    localparam int UNREACHED = MAX_VERTICES;

    typedef struct {
        logic          kind;
        logic [VW-1:0] a;
        logic [VW-1:0] b;
    } graph_op_t;

    typedef struct {
        logic [CW-1:0] count;
        logic          sat;
        status_t       status;
    } path_result_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic          kind = KIND_EDGE;
    logic [VW-1:0] vertex_a = '0;
    logic [VW-1:0] vertex_b = '0;
    logic          done;
    logic [CW-1:0] path_count;
    logic          count_saturated;
    logic [1:0]    status;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [VW:0]   cfg_data = '0;

    graph_op_t    op_q[$];       // items waiting to be driven
    path_result_t result_q[$];   // predicted results, oldest first
    int           gap_pct = 0;   // sender idle chance, percent
    int           fail_cnt = 0;
    int           ops_accepted = 0;
    int           results_seen = 0;
    int           saturated_seen = 0;
    int           quiet_cycles = 0;

    // Shadow of the block's graph and register
    logic [VW:0]   vc_shadow;
    int            head_sh[MAX_VERTICES];
    int            target_sh[MAX_EDGES];
    int            link_sh[MAX_EDGES];
    int            edges_sh;

    shortest_path_counter u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .vertex_a        (vertex_a),
        .vertex_b        (vertex_b),
        .done            (done),
        .path_count      (path_count),
        .count_saturated (count_saturated),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Vertex count as the block uses it: 0 acts as 1, above the max is clamped.
    function automatic int live_vertices();
        if (vc_shadow == 0)
            return 1;
        if (vc_shadow > MAX_VERTICES)
            return MAX_VERTICES;
        return int'(vc_shadow);
    endfunction

    // BFS with per-vertex shortest path counts, saturating adds.
    task automatic count_paths(input int src, input int dst, input int n,
                               output path_result_t r);
        int            hop[MAX_VERTICES];
        logic [CW-1:0] ways[MAX_VERTICES];
        int            visit[MAX_VERTICES];
        int            rd, wr, cur, nd, e, steps, v;
        logic [CW:0]   sum;
        logic          clamped;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            hop[i] = UNREACHED;
            ways[i] = '0;
        end
        clamped = 1'b0;
        hop[src] = 0;
        ways[src] = 1;
        visit[0] = src;
        rd = 0;
        wr = 1;
        while (rd < wr)
        begin
            cur = visit[rd];
            rd++;
            nd = hop[cur] + 1;
            e = head_sh[cur];
            steps = 0;
            while (e < MAX_EDGES && steps < MAX_EDGES)
            begin
                v = target_sh[e];
                steps++;
                // edges into vertices beyond the current count are skipped
                if (v < n)
                begin
                    if (hop[v] == UNREACHED)
                    begin
                        hop[v] = nd;
                        if (wr < MAX_VERTICES)
                        begin
                            visit[wr] = v;
                            wr++;
                        end
                    end
                    if (hop[v] == nd)
                    begin
                        sum = {1'b0, ways[v]} + {1'b0, ways[cur]};
                        if (sum[CW])
                        begin
                            clamped = 1'b1;
                            ways[v] = COUNT_TOP;
                        end
                        else
                            ways[v] = sum[CW-1:0];
                    end
                end
                e = link_sh[e];
            end
        end
        r.count = ways[dst];
        r.sat = clamped && (ways[dst] == COUNT_TOP);
        r.status = ST_OK;
    endtask

    // Apply one accepted item to the shadow graph and queue its result.
    task automatic predict_op(input graph_op_t op);
        path_result_t r;
        int           n;
        n = live_vertices();
        r.count = '0;
        r.sat = 1'b0;
        r.status = ST_OK;
        if (op.a >= n || op.b >= n)
            r.status = ST_RANGE;       // range check wins over store full
        else if (op.kind == KIND_EDGE)
        begin
            if (edges_sh >= MAX_EDGES)
                r.status = ST_FULL;
            else
            begin
                target_sh[edges_sh] = op.b;
                link_sh[edges_sh] = head_sh[op.a];
                head_sh[op.a] = edges_sh;
                edges_sh++;
            end
        end
        else
            count_paths(op.a, op.b, n, r);
        result_q.insert(result_q.size(), r);
    endtask

    // Driver: hold start with the current item until the block takes the beat,
    // then either present the next item or idle for a random cycle.
    always @(posedge clk)
    begin : drv
        logic hold;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_op(op_q.pop_front());
                ops_accepted++;
            end
            hold = start && busy;
            if (!hold)
            begin
                if (op_q.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    start    <= 1'b1;
                    kind     <= op_q[0].kind;
                    vertex_a <= op_q[0].a;
                    vertex_b <= op_q[0].b;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every done strobe is checked against the oldest prediction.
    always @(posedge clk)
    begin : mon
        path_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (count_saturated)
                saturated_seen++;
            if (result_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_cnt++;
            end
            else
            begin
                want = result_q.pop_front();
                if (path_count !== want.count)
                begin
                    $error("path_count: expected %0d, got %0d", want.count, path_count);
                    fail_cnt++;
                end
                if (count_saturated !== want.sat)
                begin
                    $error("count_saturated: expected %0d, got %0d",
                           want.sat, count_saturated);
                    fail_cnt++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles without any beat moving.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_op(input logic k, input int a, input int b);
        graph_op_t op;
        op.kind = k;
        op.a = a[VW-1:0];
        op.b = b[VW-1:0];
        op_q.insert(op_q.size(), op);
    endtask

    // Block is idle once every item is taken and every result is back.
    task automatic drain();
        do
            @(posedge clk);
        while (op_q.size() != 0 || start || result_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_vertex_count(input int v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v[VW:0];
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        vc_shadow = v[VW:0];
        cfg_valid <= 1'b0;
    endtask

    // Mostly in-range vertices; now and then a raw 10-bit value.
    function automatic int pick_vertex(input int n);
        if ($urandom_range(9) == 0)
            return $urandom_range(MAX_VERTICES - 1);
        return $urandom_range(n - 1);
    endfunction

    initial
    begin
        int pcts[3];
        int base, v, n;
        pcts = '{31, 86, 0};
        vc_shadow = MAX_VERTICES;
        edges_sh = 0;
        for (int i = 0; i < MAX_VERTICES; i++)
            head_sh[i] = MAX_EDGES;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, start == stop, unreachable, range refusals.
        gap_pct = pcts[0];
        push_op(KIND_EDGE, 0, 1023);
        push_op(KIND_EDGE, 1023, 0);
        push_op(KIND_QUERY, 0, 1023);
        push_op(KIND_QUERY, 5, 5);
        push_op(KIND_QUERY, 1023, 1023);
        push_op(KIND_QUERY, 0, 7);
        push_op(KIND_QUERY, 1023, 1);
        drain();
        write_vertex_count(0);          // acts as one vertex
        push_op(KIND_EDGE, 0, 0);
        push_op(KIND_QUERY, 0, 0);
        push_op(KIND_QUERY, 1, 0);
        push_op(KIND_EDGE, 0, 1);
        drain();
        write_vertex_count(2047);       // clamped to the max
        push_op(KIND_EDGE, 1022, 1023);
        push_op(KIND_QUERY, 1022, 0);
        drain();
        write_vertex_count(4);          // edges into 1023 are now skipped
        push_op(KIND_QUERY, 0, 1023);
        push_op(KIND_QUERY, 1023, 0);
        push_op(KIND_QUERY, 0, 0);
        drain();

        // Chain of diamonds: each stage doubles the count, 33 stages overflow.
        write_vertex_count(128);
        base = 20;
        for (int s = 0; s < 33; s++)
        begin
            v = base + 3 * s;
            push_op(KIND_EDGE, v, v + 1);
            push_op(KIND_EDGE, v, v + 2);
            push_op(KIND_EDGE, v + 1, v + 3);
            push_op(KIND_EDGE, v + 2, v + 3);
        end
        push_op(KIND_QUERY, base, base + 3 * 31);
        push_op(KIND_QUERY, base, base + 3 * 32);
        push_op(KIND_QUERY, base, base + 3 * 33);
        push_op(KIND_QUERY, base, base + 3 * 32 + 1);
        drain();

        // Random graphs under shifting vertex counts and idle patterns.
        for (int seg = 0; seg < 3; seg++)
        begin
            gap_pct = pcts[seg];
            for (int chunk = 0; chunk < 6; chunk++)
            begin
                case ($urandom_range(9))
                    0:       v = 1;
                    1:       v = ($urandom_range(1)) ? 2047 : MAX_VERTICES;
                    2:       v = 0;
                    default: v = $urandom_range(2, 48);
                endcase
                write_vertex_count(v);
                n = live_vertices();
                for (int k = 0; k < 40; k++)
                    push_op(($urandom_range(99) < 65) ? KIND_EDGE : KIND_QUERY,
                            pick_vertex(n), pick_vertex(n));
                drain();
            end
        end

        // Wide graph again, then a shrunk one with a refusal in front.
        write_vertex_count(MAX_VERTICES);
        push_op(KIND_EDGE, 3, 4);
        push_op(KIND_EDGE, 1023, 1023);
        push_op(KIND_QUERY, 0, 1023);
        drain();
        write_vertex_count(500);
        push_op(KIND_EDGE, 600, 0);     // source past the vertex count
        push_op(KIND_EDGE, 1, 2);
        push_op(KIND_QUERY, 20, 20 + 3 * 20);
        drain();
        repeat (20) @(posedge clk);

        $display("Covered %0d items, %0d results (%0d saturated), %0d edges stored.",
                 ops_accepted, results_seen, saturated_seen, edges_sh);
        if (fail_cnt == 0 && result_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
